FILE: rtl/kost_pkg.sv
// package for the keyed object set table
// types, codes and sizes shared by the controller, datapath and top level
package kost_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SEQ_W       = 23;
    localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_LOOKUP,
        OP_SEL_FIELD,
        OP_SEL_RET_EQ,
        OP_SEL_RET_NE,
        OP_CLEAR
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE,
        ST_DUP,
        ST_FULL,
        ST_NOT_FOUND,
        ST_SEL_END,
        ST_BAD_OP
    } t_status;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_RAM,
        SRC_NEW
    } t_src;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [7:0]       chan;
        logic [11:0]      fld;
        logic [23:0]      idx;
        logic [15:0]      ret;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic    capture;
        logic    advance;
        logic    emit;
        t_status status;
        t_src    src;
        logic    last;
        logic    write;
        logic    clear;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic scan_end;
        logic hit;
        logic full;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/kost_ram.sv
// generic single write port ram with registered read
// no dependencies
module kost_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/kost_ctrl.sv
// controller state machine of the keyed object set table
// depends on kost_pkg; drives the datapath by command, reads its status
module kost_ctrl
    import kost_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_is_sel;

    assign w_is_sel = (i_stat.op inside {OP_SEL_FIELD, OP_SEL_RET_EQ, OP_SEL_RET_NE});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.out_free && (i_stat.scan_end || (i_stat.hit && !w_is_sel))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    o_cmd.emit = i_stat.out_free;
                    o_cmd.last = 1'b1;
                    case (i_stat.op)
                        OP_INSERT: begin
                            if (i_stat.full) begin
                                o_cmd.status = ST_FULL;
                            end else begin
                                o_cmd.status = ST_DONE;
                                o_cmd.src    = SRC_NEW;
                                o_cmd.write  = i_stat.out_free;
                            end
                        end
                        OP_LOOKUP: o_cmd.status = ST_NOT_FOUND;
                        OP_SEL_FIELD, OP_SEL_RET_EQ, OP_SEL_RET_NE: o_cmd.status = ST_SEL_END;
                        OP_CLEAR: begin
                            o_cmd.status = ST_DONE;
                            o_cmd.clear  = i_stat.out_free;
                        end
                        default: o_cmd.status = ST_BAD_OP;
                    endcase
                end else if (i_stat.hit) begin
                    o_cmd.emit   = i_stat.out_free;
                    o_cmd.src    = SRC_RAM;
                    o_cmd.status = (i_stat.op == OP_INSERT) ? ST_DUP : ST_DONE;
                    o_cmd.last   = !w_is_sel;
                    o_cmd.advance = w_is_sel && i_stat.out_free;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/kost_dp.sv
// datapath of the keyed object set table: entry memory, scan index, count, output register
// depends on kost_pkg and kost_ram
module kost_dp
    import kost_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [2:0]         i_operation,
    input  logic signed [23:0] i_seq_number,
    input  logic [7:0]         i_channel,
    input  logic [11:0]        i_field_number,
    input  logic [23:0]        i_data_index,
    input  logic signed [15:0] i_retained,
    input  logic               i_check_duplicate,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [4:0]         o_slot,
    output logic [22:0]        o_seq_magnitude,
    output logic [7:0]         o_channel_out,
    output logic [11:0]        o_field_out,
    output logic [23:0]        o_index_out,
    output logic signed [15:0] o_retained_out,
    output logic [5:0]         o_entry_total,
    output logic               o_last
);

    t_op              r_op;
    logic             r_chk;
    logic             r_qneg;
    logic [SEQ_W-1:0] r_qseq;
    t_entry           r_new;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_entry           w_rd;
    logic [23:0]      w_abs;
    logic [SEQ_W-1:0] w_mag;
    logic             w_key_hit;

    logic             r_out_valid;
    t_status          r_out_status;
    logic [ADDR_W-1:0] r_out_slot;
    t_entry           r_out_ent;
    logic [CNT_W-1:0] r_out_total;
    logic             r_out_last;

    kost_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.write),
        .i_waddr(r_count[ADDR_W-1:0]),
        .i_wdata(r_new),
        .i_raddr(n_idx[ADDR_W-1:0]),
        .o_rdata(w_rd)
    );

    // magnitude of the query, most negative value saturated
    assign w_abs = i_seq_number[23] ? (~i_seq_number + 24'd1) : i_seq_number;
    assign w_mag = w_abs[23] ? SEQ_MAX : w_abs[SEQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= t_op'(i_operation);
            r_chk     <= i_check_duplicate;
            r_qneg    <= i_seq_number[23];
            r_qseq    <= i_seq_number[SEQ_W-1:0];
            r_new.seq  <= w_mag;
            r_new.chan <= i_channel;
            r_new.fld  <= i_field_number;
            r_new.idx  <= i_data_index;
            r_new.ret  <= i_retained;
        end
    end

    // read address follows the next index so read data always matches r_idx
    always_comb begin
        if (i_cmd.capture) begin
            n_idx = '0;
        end else if (i_cmd.advance) begin
            n_idx = r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_comb begin
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.write) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_idx   <= n_idx;
            r_count <= n_count;
        end
    end

    assign w_key_hit = !r_qneg && (w_rd.seq == r_qseq) && (w_rd.chan == r_new.chan);

    always_comb begin
        o_stat          = '0;
        o_stat.op       = r_op;
        o_stat.full     = (r_count >= CNT_W'(TABLE_DEPTH));
        o_stat.out_free = !r_out_valid || i_ready;
        case (r_op)
            OP_INSERT: begin
                o_stat.scan_end = !r_chk || (r_idx >= r_count);
                o_stat.hit      = w_key_hit;
            end
            OP_LOOKUP: begin
                o_stat.scan_end = (r_idx >= r_count);
                o_stat.hit      = w_key_hit;
            end
            OP_SEL_FIELD: begin
                o_stat.scan_end = (r_idx >= r_count);
                o_stat.hit      = (w_rd.fld == r_new.fld);
            end
            OP_SEL_RET_EQ: begin
                o_stat.scan_end = (r_idx >= r_count);
                o_stat.hit      = (w_rd.ret == r_new.ret);
            end
            OP_SEL_RET_NE: begin
                o_stat.scan_end = (r_idx >= r_count);
                o_stat.hit      = (w_rd.ret != r_new.ret);
            end
            default: begin
                o_stat.scan_end = 1'b1;
                o_stat.hit      = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.status;
            r_out_last   <= i_cmd.last;
            r_out_total  <= n_count;
            case (i_cmd.src)
                SRC_RAM: begin
                    r_out_slot <= r_idx[ADDR_W-1:0];
                    r_out_ent  <= w_rd;
                end
                SRC_NEW: begin
                    r_out_slot <= r_count[ADDR_W-1:0];
                    r_out_ent  <= r_new;
                end
                default: begin
                    r_out_slot <= '0;
                    r_out_ent  <= '0;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot          = r_out_slot;
    assign o_seq_magnitude = r_out_ent.seq;
    assign o_channel_out   = r_out_ent.chan;
    assign o_field_out     = r_out_ent.fld;
    assign o_index_out     = r_out_ent.idx;
    assign o_retained_out  = r_out_ent.ret;
    assign o_entry_total   = r_out_total;
    assign o_last          = r_out_last;

endmodule

FILE: rtl/keyed_object_set_table.sv
// top level of the keyed object set table
// depends on kost_pkg, kost_ctrl and kost_dp
//
// usage:
//   input channel i_valid / o_ready carries one operation per transaction:
//   insert, lookup, three kinds of select, or clear.
//   output channel o_valid / i_ready carries result transactions; o_last
//   marks the final result of an operation.
//   one operation at a time: o_ready is high only while no operation is
//   in progress. the scan reads the stored entries one slot per cycle,
//   unless a match waits for the output register to free; lookup and
//   duplicate check stop at the first match, and insert without duplicate
//   check, clear and bad codes finish without scanning any slot.
//   a single output register holds the last result, so the next operation
//   is taken while that result waits; a stalled receiver holds the scan
//   at the matching slot until the register frees.
//   reset empties the table (entry count zero); no clearing pass is
//   needed since only slots below the count are read.
module keyed_object_set_table
    import kost_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_operation,
    input  logic signed [23:0] i_seq_number,
    input  logic [7:0]         i_channel,
    input  logic [11:0]        i_field_number,
    input  logic [23:0]        i_data_index,
    input  logic signed [15:0] i_retained,
    input  logic               i_check_duplicate,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [4:0]         o_slot,
    output logic [22:0]        o_seq_magnitude,
    output logic [7:0]         o_channel_out,
    output logic [11:0]        o_field_out,
    output logic [23:0]        o_index_out,
    output logic signed [15:0] o_retained_out,
    output logic [5:0]         o_entry_total,
    output logic               o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    kost_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_stat (w_stat),
        .o_cmd  (w_cmd)
    );

    kost_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_operation      (i_operation),
        .i_seq_number     (i_seq_number),
        .i_channel        (i_channel),
        .i_field_number   (i_field_number),
        .i_data_index     (i_data_index),
        .i_retained       (i_retained),
        .i_check_duplicate(i_check_duplicate),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_seq_magnitude  (o_seq_magnitude),
        .o_channel_out    (o_channel_out),
        .o_field_out      (o_field_out),
        .o_index_out      (o_index_out),
        .o_retained_out   (o_retained_out),
        .o_entry_total    (o_entry_total),
        .o_last           (o_last)
    );

endmodule
